// ----- hw/rtl/vms_pkg.sv -----
// vms_pkg: shared types, constants and helpers of the vehicle motion step block
// payload structs for the input and result channels, register codes, arc table
// no dependencies
package vms_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int ANGLE_STEPS = 16;

  // fixed point widths that follow from the fraction width
  localparam int RW     = 8 + FRAC_BITS;   // half size in fixed point
  localparam int SPAN_W = 11 + FRAC_BITS;  // field span in fixed point
  localparam int EDGE_W = SPAN_W + 2;      // signed span plus margin

  localparam logic signed [25:0] HALF_PI   = 26'sd4194304;
  localparam logic signed [26:0] GAIN_Q24  = 27'sd10188014;
  localparam logic signed [19:0] VEL_RESET = 20'(4 << FRAC_BITS);

  localparam logic [2:0] CFG_MAX_SPEED    = 3'd0;
  localparam logic [2:0] CFG_HALF_SIZE    = 3'd1;
  localparam logic [2:0] CFG_FIELD_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_FIELD_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_START_X      = 3'd4;
  localparam logic [2:0] CFG_START_Y      = 3'd5;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
  } in_t;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] vel_x;
    logic signed [19:0] vel_y;
    logic signed [15:0] heading;
    logic signed [19:0] tail_left_x;
    logic signed [19:0] tail_left_y;
    logic signed [19:0] tail_right_x;
    logic signed [19:0] tail_right_y;
    logic signed [19:0] nose_x;
    logic signed [19:0] nose_y;
  } out_t;

  function automatic logic signed [19:0] sat20(input logic signed [31:0] v);
    logic signed [19:0] r;
    if (v > 32'sd524287) r = 20'sd524287;
    else if (v < -32'sd524288) r = -20'sd524288;
    else r = v[19:0];
    return r;
  endfunction

  // atan(2^-i) with pi = 2^23
  function automatic logic signed [25:0] arc_of(input logic [4:0] i);
    logic signed [25:0] a;
    unique case (i)
      5'd0:  a = 26'sd2097152;
      5'd1:  a = 26'sd1238021;
      5'd2:  a = 26'sd654136;
      5'd3:  a = 26'sd332050;
      5'd4:  a = 26'sd166669;
      5'd5:  a = 26'sd83416;
      5'd6:  a = 26'sd41718;
      5'd7:  a = 26'sd20860;
      5'd8:  a = 26'sd10430;
      5'd9:  a = 26'sd5215;
      5'd10: a = 26'sd2608;
      5'd11: a = 26'sd1304;
      5'd12: a = 26'sd652;
      5'd13: a = 26'sd326;
      5'd14: a = 26'sd163;
      5'd15: a = 26'sd81;
      5'd16: a = 26'sd41;
      5'd17: a = 26'sd20;
      5'd18: a = 26'sd10;
      5'd19: a = 26'sd5;
      5'd20: a = 26'sd3;
      5'd21: a = 26'sd1;
      5'd22: a = 26'sd1;
      default: a = 26'sd0;
    endcase
    return a;
  endfunction

endpackage

// ----- hw/rtl/vehicle_motion_step.sv -----
// vehicle_motion_step: one Euler update of a steered vehicle per input transfer
// sequencer with bit-serial square root and divider, iterative CORDIC units
// depends on vms_pkg
//
// Usage: each transfer on in_ (valid/stall) is one frame tick with the summed
// acceleration. The block wraps the stored position at the field edges, adds
// the acceleration, limits the speed, moves the position and returns one
// result on out_ (valid/stall): position, velocity, heading and the three
// triangle vertices. cfg_ writes (valid/ready, always ready) set the speed
// limit, half size and field size; write them only while the block is idle.
// Start position registers are accepted but only the reset value counts.
// Each item runs the 16-step heading CORDIC loop and the 16-step rotation loop;
// at zero velocity the heading loop is skipped, and when the speed limit applies
// 21 square-root steps and two 40-step bit-serial divisions come first. The next
// transfer can be taken in the cycle in which the result is shown.
// One item is in work at a time; in_stall is high until it is finished.
// A finished result waits in the output register while out_stall is high;
// the next item can already be taken in. Reset restores the registers,
// puts the vehicle at the origin with velocity 4.0 and clears out_valid.
module vehicle_motion_step (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  vms_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output vms_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_WRAP  = 5'd1;
  localparam logic [4:0] S_SQX   = 5'd2;
  localparam logic [4:0] S_SQY   = 5'd3;
  localparam logic [4:0] S_SUM   = 5'd4;
  localparam logic [4:0] S_CMP   = 5'd5;
  localparam logic [4:0] S_SQRT  = 5'd6;
  localparam logic [4:0] S_MULX  = 5'd7;
  localparam logic [4:0] S_DIVX  = 5'd8;
  localparam logic [4:0] S_MULY  = 5'd9;
  localparam logic [4:0] S_DIVY  = 5'd10;
  localparam logic [4:0] S_VUPD  = 5'd11;
  localparam logic [4:0] S_PUPD  = 5'd12;
  localparam logic [4:0] S_HINIT = 5'd13;
  localparam logic [4:0] S_HITER = 5'd14;
  localparam logic [4:0] S_HEND  = 5'd15;
  localparam logic [4:0] S_CINIT = 5'd16;
  localparam logic [4:0] S_CITER = 5'd17;
  localparam logic [4:0] S_PROD  = 5'd18;
  localparam logic [4:0] S_PLACE = 5'd19;
  localparam logic [4:0] S_OUT   = 5'd20;

  localparam logic [5:0] LAST_SQRT = 6'd20;
  localparam logic [5:0] LAST_DIV  = 6'd39;
  localparam logic [5:0] LAST_ROT  = 6'(vms_pkg::ANGLE_STEPS - 1);

  // configuration
  logic [15:0]                  max_speed_r;
  logic [7:0]                   half_size_r;
  logic [10:0]                  field_w_r;
  logic [10:0]                  field_h_r;

  logic [4:0]                   state_r, state_nxt;
  logic [5:0]                   cnt_r, cnt_nxt;
  logic signed [19:0]           pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [19:0]           vel_x_r, vel_x_nxt, vel_y_r, vel_y_nxt;
  logic signed [15:0]           acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic signed [20:0]           vx_r, vx_nxt, vy_r, vy_nxt;
  logic [39:0]                  mul_r, mul_nxt;
  logic [40:0]                  sum_r, sum_nxt;
  logic                         clamp_r, clamp_nxt;
  logic [40:0]                  sq_n_r, sq_n_nxt;
  logic [41:0]                  sq_res_r, sq_res_nxt, sq_bit_r, sq_bit_nxt;
  logic [20:0]                  rem_r, rem_nxt;
  logic signed [38:0]           hx_r, hx_nxt, hy_r, hy_nxt;
  logic signed [25:0]           hz_r, hz_nxt;
  logic signed [15:0]           head_r, head_nxt;
  logic signed [26:0]           cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [25:0]           ca_r, ca_nxt;
  logic signed [43:0]           pcr_r, pcr_nxt, psr_r, psr_nxt, pch_r, pch_nxt, psh_r, psh_nxt;
  vms_pkg::out_t                res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  vms_pkg::out_t                out_data_r, out_data_nxt;

  // datapath helpers
  logic [vms_pkg::RW-1:0]       r_fx, h_fx;
  logic [vms_pkg::SPAN_W-1:0]   w_fx, hgt_fx;
  logic signed [20:0]           vx_neg, vy_neg;
  logic [19:0]                  vx_abs, vy_abs;
  logic [19:0]                  mul_a, mul_b;
  logic [39:0]                  mul_p;
  logic [21:0]                  rem_sh;
  logic                         div_ge;
  logic [41:0]                  sq_trial;
  logic                         sq_ge;
  logic signed [38:0]           hx0, hy0, hdx, hdy;
  logic signed [25:0]           arc, ca0;
  logic signed [26:0]           cdx, cdy;
  logic signed [26:0]           op_c;
  logic [vms_pkg::RW-1:0]       op_r;
  logic signed [43:0]           prod;
  logic signed [45:0]           pl_t;
  logic signed [21:0]           pl_q;
  logic signed [19:0]           pl_pos, pl_val;

  function automatic logic signed [19:0] wrap_edge(
    input logic signed [19:0]        p,
    input logic [vms_pkg::SPAN_W-1:0] span,
    input logic [vms_pkg::RW-1:0]     r
  );
    logic signed [vms_pkg::EDGE_W-1:0] hi, lo, pe;
    logic signed [19:0]                res;
    hi = $signed(vms_pkg::EDGE_W'(span) + vms_pkg::EDGE_W'(r));
    lo = -$signed(vms_pkg::EDGE_W'(r));
    pe = vms_pkg::EDGE_W'(p);
    if (pe > hi) res = vms_pkg::sat20(32'(lo));
    else if (pe < lo) res = vms_pkg::sat20(32'(hi));
    else res = p;
    return res;
  endfunction

  assign r_fx   = {half_size_r, {vms_pkg::FRAC_BITS{1'b0}}};
  assign h_fx   = r_fx >> 1;
  assign w_fx   = {field_w_r, {vms_pkg::FRAC_BITS{1'b0}}};
  assign hgt_fx = {field_h_r, {vms_pkg::FRAC_BITS{1'b0}}};

  assign vx_neg = -vx_r;
  assign vy_neg = -vy_r;
  assign vx_abs = vx_r[20] ? vx_neg[19:0] : vx_r[19:0];
  assign vy_abs = vy_r[20] ? vy_neg[19:0] : vy_r[19:0];

  // shared 20x20 multiplier for squares, limit squared and scaling
  always_comb begin
    unique case (state_r)
      S_SQX:   begin mul_a = vx_abs;              mul_b = vx_abs;              end
      S_SQY:   begin mul_a = vy_abs;              mul_b = vy_abs;              end
      S_SUM:   begin mul_a = 20'(max_speed_r);    mul_b = 20'(max_speed_r);    end
      S_MULX:  begin mul_a = vx_abs;              mul_b = 20'(max_speed_r);    end
      S_MULY:  begin mul_a = vy_abs;              mul_b = 20'(max_speed_r);    end
      default: begin mul_a = '0;                  mul_b = '0;                  end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // one quotient bit per cycle, dividend shifts out of mul_r and quotient in
  assign rem_sh = {rem_r, mul_r[39]};
  assign div_ge = rem_sh >= {1'b0, sq_res_r[20:0]};

  // one result bit of the square root per cycle
  assign sq_trial = sq_res_r + sq_bit_r;
  assign sq_ge    = {1'b0, sq_n_r} >= sq_trial;

  assign hx0 = {{3{vel_x_r[19]}}, vel_x_r, 16'b0};
  assign hy0 = {{3{vel_y_r[19]}}, vel_y_r, 16'b0};
  assign hdx = hx_r >>> cnt_r[4:0];
  assign hdy = hy_r >>> cnt_r[4:0];
  assign arc = vms_pkg::arc_of(cnt_r[4:0]);
  assign ca0 = 26'($signed({head_r, 8'b0}));
  assign cdx = cx_r >>> cnt_r[4:0];
  assign cdy = cy_r >>> cnt_r[4:0];

  // rotation products: cos*r, sin*r, cos*r/2, sin*r/2
  assign op_c = cnt_r[0] ? cy_r : cx_r;
  assign op_r = cnt_r[1] ? h_fx : r_fx;
  assign prod = op_c * $signed({1'b0, op_r});

  always_comb begin
    unique case (cnt_r[2:0])
      3'd0:    pl_t = -46'(pcr_r) + 46'(psh_r);
      3'd1:    pl_t = -46'(psr_r) - 46'(pch_r);
      3'd2:    pl_t = -46'(pcr_r) - 46'(psh_r);
      3'd3:    pl_t = -46'(psr_r) + 46'(pch_r);
      3'd4:    pl_t = 46'(pcr_r);
      3'd5:    pl_t = 46'(psr_r);
      default: pl_t = '0;
    endcase
  end
  assign pl_q   = 22'((pl_t + 46'sd8388608) >>> 24);
  assign pl_pos = cnt_r[0] ? pos_y_r : pos_x_r;
  assign pl_val = vms_pkg::sat20(32'(pl_q) + 32'(pl_pos));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    vel_x_nxt     = vel_x_r;
    vel_y_nxt     = vel_y_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    mul_nxt       = mul_r;
    sum_nxt       = sum_r;
    clamp_nxt     = clamp_r;
    sq_n_nxt      = sq_n_r;
    sq_res_nxt    = sq_res_r;
    sq_bit_nxt    = sq_bit_r;
    rem_nxt       = rem_r;
    hx_nxt        = hx_r;
    hy_nxt        = hy_r;
    hz_nxt        = hz_r;
    head_nxt      = head_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    ca_nxt        = ca_r;
    pcr_nxt       = pcr_r;
    psr_nxt       = psr_r;
    pch_nxt       = pch_r;
    psh_nxt       = psh_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          acc_x_nxt = in_data.accel_x;
          acc_y_nxt = in_data.accel_y;
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        pos_x_nxt = wrap_edge(pos_x_r, w_fx, r_fx);
        pos_y_nxt = wrap_edge(pos_y_r, hgt_fx, r_fx);
        vx_nxt    = 21'(vel_x_r) + 21'(acc_x_r);
        vy_nxt    = 21'(vel_y_r) + 21'(acc_y_r);
        state_nxt = S_SQX;
      end
      S_SQX: begin
        mul_nxt   = mul_p;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        sum_nxt   = 41'(mul_r);
        mul_nxt   = mul_p;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        sum_nxt   = sum_r + 41'(mul_r);
        mul_nxt   = mul_p;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        clamp_nxt  = sum_r > {1'b0, mul_r};
        sq_n_nxt   = sum_r;
        sq_res_nxt = '0;
        sq_bit_nxt = 42'd1 << 40;
        cnt_nxt    = '0;
        state_nxt  = (sum_r > {1'b0, mul_r}) ? S_SQRT : S_VUPD;
      end
      S_SQRT: begin
        if (sq_ge) begin
          sq_n_nxt   = 41'(42'(sq_n_r) - sq_trial);
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == LAST_SQRT) state_nxt = S_MULX;
      end
      S_MULX, S_MULY: begin
        mul_nxt   = mul_p;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = (state_r == S_MULX) ? S_DIVX : S_DIVY;
      end
      S_DIVX, S_DIVY: begin
        rem_nxt = div_ge ? 21'(rem_sh - {1'b0, sq_res_r[20:0]}) : rem_sh[20:0];
        mul_nxt = {mul_r[38:0], div_ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == LAST_DIV) begin
          if (state_r == S_DIVX) begin
            vx_nxt    = vx_r[20] ? -$signed({1'b0, mul_nxt[19:0]})
                                 : $signed({1'b0, mul_nxt[19:0]});
            state_nxt = S_MULY;
          end else begin
            vy_nxt    = vy_r[20] ? -$signed({1'b0, mul_nxt[19:0]})
                                 : $signed({1'b0, mul_nxt[19:0]});
            state_nxt = S_VUPD;
          end
        end
      end
      S_VUPD: begin
        vel_x_nxt = vms_pkg::sat20(32'(vx_r));
        vel_y_nxt = vms_pkg::sat20(32'(vy_r));
        state_nxt = S_PUPD;
      end
      S_PUPD: begin
        pos_x_nxt = vms_pkg::sat20(32'(pos_x_r) + 32'(vel_x_r));
        pos_y_nxt = vms_pkg::sat20(32'(pos_y_r) + 32'(vel_y_r));
        state_nxt = S_HINIT;
      end
      S_HINIT: begin
        cnt_nxt = '0;
        if (vel_x_r == '0 && vel_y_r == '0) begin
          head_nxt  = '0;
          state_nxt = S_CINIT;
        end else begin
          state_nxt = S_HITER;
          if (hx0 < 0) begin
            if (hy0 >= 0) begin
              hx_nxt = hy0;
              hy_nxt = -hx0;
              hz_nxt = vms_pkg::HALF_PI;
            end else begin
              hx_nxt = -hy0;
              hy_nxt = hx0;
              hz_nxt = -vms_pkg::HALF_PI;
            end
          end else begin
            hx_nxt = hx0;
            hy_nxt = hy0;
            hz_nxt = '0;
          end
        end
      end
      S_HITER: begin
        // drive y toward zero, angle collects in z
        if (hy_r > 0) begin
          hx_nxt = hx_r + hdy;
          hy_nxt = hy_r - hdx;
          hz_nxt = hz_r + arc;
        end else begin
          hx_nxt = hx_r - hdy;
          hy_nxt = hy_r + hdx;
          hz_nxt = hz_r - arc;
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == LAST_ROT) state_nxt = S_HEND;
      end
      S_HEND: begin
        head_nxt  = 16'((hz_r + 26'sd128) >>> 8);
        state_nxt = S_CINIT;
      end
      S_CINIT: begin
        cnt_nxt = '0;
        if (ca0 > vms_pkg::HALF_PI) begin
          cx_nxt = '0;
          cy_nxt = vms_pkg::GAIN_Q24;
          ca_nxt = ca0 - vms_pkg::HALF_PI;
        end else if (ca0 < -vms_pkg::HALF_PI) begin
          cx_nxt = '0;
          cy_nxt = -vms_pkg::GAIN_Q24;
          ca_nxt = ca0 + vms_pkg::HALF_PI;
        end else begin
          cx_nxt = vms_pkg::GAIN_Q24;
          cy_nxt = '0;
          ca_nxt = ca0;
        end
        state_nxt = S_CITER;
      end
      S_CITER: begin
        if (ca_r >= 0) begin
          cx_nxt = cx_r - cdy;
          cy_nxt = cy_r + cdx;
          ca_nxt = ca_r - arc;
        end else begin
          cx_nxt = cx_r + cdy;
          cy_nxt = cy_r - cdx;
          ca_nxt = ca_r + arc;
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == LAST_ROT) begin
          cnt_nxt   = '0;
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        unique case (cnt_r[1:0])
          2'd0: pcr_nxt = prod;
          2'd1: psr_nxt = prod;
          2'd2: pch_nxt = prod;
          2'd3: psh_nxt = prod;
        endcase
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        unique case (cnt_r[2:0])
          3'd0:    res_nxt.tail_left_x  = pl_val;
          3'd1:    res_nxt.tail_left_y  = pl_val;
          3'd2:    res_nxt.tail_right_x = pl_val;
          3'd3:    res_nxt.tail_right_y = pl_val;
          3'd4:    res_nxt.nose_x       = pl_val;
          3'd5:    res_nxt.nose_y       = pl_val;
          default: res_nxt = res_r;
        endcase
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd5) state_nxt = S_OUT;
      end
      S_OUT: begin
        // waits here only while an older result is still stalled
        if (!out_valid_r || !out_stall) begin
          out_data_nxt         = res_r;
          out_data_nxt.pos_x   = pos_x_r;
          out_data_nxt.pos_y   = pos_y_r;
          out_data_nxt.vel_x   = vel_x_r;
          out_data_nxt.vel_y   = vel_y_r;
          out_data_nxt.heading = head_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= 16'd1024;
      half_size_r <= 8'd16;
      field_w_r   <= 11'd600;
      field_h_r   <= 11'd400;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vms_pkg::CFG_MAX_SPEED:    max_speed_r <= cfg_data;
        vms_pkg::CFG_HALF_SIZE:    half_size_r <= cfg_data[7:0];
        vms_pkg::CFG_FIELD_WIDTH:  field_w_r   <= cfg_data[10:0];
        vms_pkg::CFG_FIELD_HEIGHT: field_h_r   <= cfg_data[10:0];
        // start position only matters at reset, where it is zero
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      vel_x_r     <= vms_pkg::VEL_RESET;
      vel_y_r     <= '0;
      clamp_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      vel_x_r     <= vel_x_nxt;
      vel_y_r     <= vel_y_nxt;
      clamp_r     <= clamp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_x_r    <= acc_x_nxt;
    acc_y_r    <= acc_y_nxt;
    vx_r       <= vx_nxt;
    vy_r       <= vy_nxt;
    mul_r      <= mul_nxt;
    sum_r      <= sum_nxt;
    sq_n_r     <= sq_n_nxt;
    sq_res_r   <= sq_res_nxt;
    sq_bit_r   <= sq_bit_nxt;
    rem_r      <= rem_nxt;
    hx_r       <= hx_nxt;
    hy_r       <= hy_nxt;
    hz_r       <= hz_nxt;
    head_r     <= head_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    ca_r       <= ca_nxt;
    pcr_r      <= pcr_nxt;
    psr_r      <= psr_nxt;
    pch_r      <= pch_nxt;
    psh_r      <= psh_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a tick is in work");

  a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VUPD && clamp_r) |->
      (vx_abs <= 20'(max_speed_r) && vy_abs <= 20'(max_speed_r)))
    else $error("clamped velocity above speed limit");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_OUT)
    else $error("result shown outside the output step");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled result overwritten by the sequencer");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking bench for vehicle_motion_step, fixed-point Euler update
// holds a bit-accurate motion predictor, directed and random tick stimulus and result checker
// depends on vms_pkg and vehicle_motion_step
module tb_top;

  localparam int LIMIT_CYCLES = 5000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  vms_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  vms_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #5 clk = ~clk;

  vehicle_motion_step dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state and registers
  longint speed_lim, half_px, span_w, span_h;
  longint p_x, p_y, v_x, v_y;
  vms_pkg::out_t pending_frames[$];
  int fail_count = 0;
  longint cycle_count = 0;
  bit stall_enable = 1'b1;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic longint arc_step(int i);
    longint arcs[24] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                         20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
                         41, 20, 10, 5, 3, 1, 1, 0};
    return arcs[i];
  endfunction

  function automatic longint int_root(longint n);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint scale_toward_zero(longint v, longint num, longint den);
    longint mag;
    mag = ((v < 0) ? -v : v) * num / den;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint angle_of(longint vx, longint vy);
    longint x, y, z, t, dx, dy;
    logic [15:0] h;
    if (vx == 0 && vy == 0) return 0;
    x = vx * 65536;
    y = vy * 65536;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 4194304;
      end else begin
        x = -y; y = t; z = -4194304;
      end
    end
    for (int i = 0; i < vms_pkg::ANGLE_STEPS; i++) begin
      dx = shr_floor(x, i);
      dy = shr_floor(y, i);
      if (y > 0) begin
        x += dy; y -= dx; z += arc_step(i);
      end else begin
        x -= dy; y += dx; z -= arc_step(i);
      end
    end
    h = 16'(shr_floor(z + 128, 8));
    return longint'($signed(h));
  endfunction

  task automatic rotate_place(input longint c, input longint s, input longint lx,
                              input longint ly, output logic [19:0] ox,
                              output logic [19:0] oy);
    ox = 20'(clip20(shr_floor(c * lx - s * ly + (64'sd1 <<< 23), 24) + p_x));
    oy = 20'(clip20(shr_floor(s * lx + c * ly + (64'sd1 <<< 23), 24) + p_y));
  endtask

  function automatic longint wrap_at(longint p, longint span, longint r);
    if (p > span + r) return clip20(-r);
    if (p < -r) return clip20(span + r);
    return p;
  endfunction

  task automatic predict_tick(input vms_pkg::in_t acc);
    longint r, vx, vy, mag, head, a, c, s, dx, dy;
    vms_pkg::out_t o;
    r = half_px <<< vms_pkg::FRAC_BITS;
    p_x = wrap_at(p_x, span_w <<< vms_pkg::FRAC_BITS, r);
    p_y = wrap_at(p_y, span_h <<< vms_pkg::FRAC_BITS, r);
    vx = v_x + longint'(acc.accel_x);
    vy = v_y + longint'(acc.accel_y);
    if (vx * vx + vy * vy > speed_lim * speed_lim) begin
      mag = int_root(vx * vx + vy * vy);
      vx = scale_toward_zero(vx, speed_lim, mag);
      vy = scale_toward_zero(vy, speed_lim, mag);
    end
    v_x = clip20(vx);
    v_y = clip20(vy);
    p_x = clip20(p_x + v_x);
    p_y = clip20(p_y + v_y);
    head = angle_of(v_x, v_y);
    // cosine and sine of the heading by rotation mode cordic
    a = head * 256;
    c = 10188014;
    s = 0;
    if (a > 4194304) begin
      c = 0; s = 10188014; a -= 4194304;
    end else if (a < -4194304) begin
      c = 0; s = -10188014; a += 4194304;
    end
    for (int i = 0; i < vms_pkg::ANGLE_STEPS; i++) begin
      dx = shr_floor(c, i);
      dy = shr_floor(s, i);
      if (a >= 0) begin
        c -= dy; s += dx; a -= arc_step(i);
      end else begin
        c += dy; s -= dx; a += arc_step(i);
      end
    end
    o.pos_x = 20'(p_x);
    o.pos_y = 20'(p_y);
    o.vel_x = 20'(v_x);
    o.vel_y = 20'(v_y);
    o.heading = 16'(head);
    rotate_place(c, s, -r, -(r >>> 1), o.tail_left_x, o.tail_left_y);
    rotate_place(c, s, -r, r >>> 1, o.tail_right_x, o.tail_right_y);
    rotate_place(c, s, r, 0, o.nose_x, o.nose_y);
    pending_frames.push_back(o);
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 3);
  endfunction

  // result checker
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $error("result with no expectation waiting");
        fail_count++;
      end else begin
        automatic vms_pkg::out_t e = pending_frames.pop_front();
        if (out_data.pos_x !== e.pos_x) begin
          $error("pos_x exp %0d got %0d", e.pos_x, out_data.pos_x); fail_count++;
        end
        if (out_data.pos_y !== e.pos_y) begin
          $error("pos_y exp %0d got %0d", e.pos_y, out_data.pos_y); fail_count++;
        end
        if (out_data.vel_x !== e.vel_x) begin
          $error("vel_x exp %0d got %0d", e.vel_x, out_data.vel_x); fail_count++;
        end
        if (out_data.vel_y !== e.vel_y) begin
          $error("vel_y exp %0d got %0d", e.vel_y, out_data.vel_y); fail_count++;
        end
        if (out_data.heading !== e.heading) begin
          $error("heading exp %0d got %0d", e.heading, out_data.heading); fail_count++;
        end
        if (out_data.tail_left_x !== e.tail_left_x) begin
          $error("tail_left_x exp %0d got %0d", e.tail_left_x, out_data.tail_left_x);
          fail_count++;
        end
        if (out_data.tail_left_y !== e.tail_left_y) begin
          $error("tail_left_y exp %0d got %0d", e.tail_left_y, out_data.tail_left_y);
          fail_count++;
        end
        if (out_data.tail_right_x !== e.tail_right_x) begin
          $error("tail_right_x exp %0d got %0d", e.tail_right_x, out_data.tail_right_x);
          fail_count++;
        end
        if (out_data.tail_right_y !== e.tail_right_y) begin
          $error("tail_right_y exp %0d got %0d", e.tail_right_y, out_data.tail_right_y);
          fail_count++;
        end
        if (out_data.nose_x !== e.nose_x) begin
          $error("nose_x exp %0d got %0d", e.nose_x, out_data.nose_x); fail_count++;
        end
        if (out_data.nose_y !== e.nose_y) begin
          $error("nose_y exp %0d got %0d", e.nose_y, out_data.nose_y); fail_count++;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (stall_enable && $urandom_range(0, 2) == 0) begin
        n = gap_len();
        out_stall <= 1'b1;
        repeat (n + 1) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_tick(input vms_pkg::in_t acc);
    int n;
    n = gap_len();
    repeat (n) @(posedge clk);
    in_data <= acc;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_tick(acc);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      vms_pkg::CFG_MAX_SPEED:    speed_lim = val;
      vms_pkg::CFG_HALF_SIZE:    half_px = val[7:0];
      vms_pkg::CFG_FIELD_WIDTH:  span_w = val[10:0];
      vms_pkg::CFG_FIELD_HEIGHT: span_h = val[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_field(input int ms, input int hs, input int fw, input int fh);
    wait_drained();
    write_reg(vms_pkg::CFG_MAX_SPEED, 16'(ms));
    write_reg(vms_pkg::CFG_HALF_SIZE, 16'(hs));
    write_reg(vms_pkg::CFG_FIELD_WIDTH, 16'(fw));
    write_reg(vms_pkg::CFG_FIELD_HEIGHT, 16'(fh));
  endtask

  function automatic vms_pkg::in_t tick_of(int ax, int ay);
    vms_pkg::in_t t;
    t.accel_x = 16'(ax);
    t.accel_y = 16'(ay);
    return t;
  endfunction

  task automatic test_directed_extremes();
    // start registers only matter at reset, written here to exercise the port
    write_reg(vms_pkg::CFG_START_X, 16'h0800);
    write_reg(vms_pkg::CFG_START_Y, 16'h07ff);
    send_tick(tick_of(0, 0));
    send_tick(tick_of(-1024, 0));        // zero velocity, heading zero
    send_tick(tick_of(32767, 32767));    // speed clamp
    send_tick(tick_of(-32768, -32768));
    send_tick(tick_of(-32768, 0));       // heading near -pi
    send_tick(tick_of(0, 32767));
    send_tick(tick_of(0, -32768));
    send_tick(tick_of(-1, 1));
    set_field(65535, 255, 2047, 2047);
    for (int i = 0; i < 6; i++) send_tick(tick_of(32767, -32768));
    set_field(0, 0, 0, 0);               // zero speed, zero field
    send_tick(tick_of(100, -100));
    send_tick(tick_of(-32768, 32767));
    set_field(300, 1, 1, 1);             // tiny field, position wraps at the edges
    for (int i = 0; i < 6; i++) send_tick(tick_of(-200, 150));
  endtask

  task automatic test_random_flight(input int count);
    int ax, ay;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        ax = $urandom_range(0, 65535) - 32768;
        ay = $urandom_range(0, 65535) - 32768;
      end else begin
        ax = $urandom_range(0, 1023) - 512;
        ay = $urandom_range(0, 1023) - 512;
      end
      send_tick(tick_of(ax, ay));
    end
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 6; ph++) begin
      set_field($urandom_range(0, 65535) >> $urandom_range(0, 8), $urandom_range(0, 255),
                $urandom_range(0, 2047), $urandom_range(0, 2047));
      test_random_flight(200);
    end
  endtask

  task automatic test_drain_pause();
    // sender holds off until every result is back, with no receiver stall
    stall_enable = 1'b0;
    set_field(1024, 16, 600, 400);
    test_random_flight(50);
    wait_drained();
    test_random_flight(50);
    stall_enable = 1'b1;
  endtask

  initial begin
    speed_lim = 1024; half_px = 16; span_w = 600; span_h = 400;
    p_x = 0; p_y = 0; v_x = 1024; v_y = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_drain_pause();
    test_random_settings();
    test_random_flight(200);
    wait_drained();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- vehicle_motion_step.f -----
hw/rtl/vms_pkg.sv
hw/rtl/vehicle_motion_step.sv
sim/tb_top.sv
